FILE: src/bbc_pkg.sv
// ---------------------------------------------------------------------------
// Buffer cache manager package
// Shared widths, operation and error codes, and controller/datapath structs.
// ---------------------------------------------------------------------------
package bbc_pkg;

    localparam int NUM_BUFFERS_DEF = 32;
    localparam int REF_WIDTH_DEF   = 8;
    localparam int MAX_OUT         = 32;

    localparam int FUNC_W  = 2;
    localparam int DEV_W   = 8;
    localparam int BLK_W   = 32;
    localparam int BIDX_W  = 5;
    localparam int SLOT_W  = 5;
    localparam int ERR_W   = 2;
    localparam int KCNT_W  = $clog2(MAX_OUT + 1);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_GET     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SYNC    = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_FREE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNREF   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_wr;
        logic load_req;
        logic decode;
        logic get_decide;
        logic rm_rd;
        logic rm_upd;
        logic rel_decide;
        logic push2;
        logic sync_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              init_last;
        logic [FUNC_W-1:0] func;
        logic              hit_any;
        logic              hit_zero;
        logic              free_empty;
        logic              rel_bad;
        logic              rel_to_zero;
        logic              pend_last;
        logic              out_free;
    } t_sts;

endpackage

FILE: src/bbc_if.sv
// ---------------------------------------------------------------------------
// Buffer cache manager channels
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface bbc_req_if import bbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DEV_W-1:0]  device_id;
    logic [BLK_W-1:0]  block_number;
    logic [BIDX_W-1:0] buffer_index;
    logic              mark_dirty;

    modport source (output valid, func, device_id, block_number, buffer_index,
                    mark_dirty, input ready);
    modport sink (input valid, func, device_id, block_number, buffer_index,
                  mark_dirty, output ready);
endinterface

interface bbc_rsp_if import bbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              need_read;
    logic              need_write;
    logic [ERR_W-1:0]  error_code;
    logic              last;

    modport source (output valid, slot, hit, need_read, need_write, error_code,
                    last, input ready);
    modport sink (input valid, slot, hit, need_read, need_write, error_code,
                  last, output ready);
endinterface

FILE: src/block_buffer_cache_manager.sv
// ---------------------------------------------------------------------------
// Block buffer cache manager
// Pool of disk block buffers with tag lookup, reference counts, dirty marks
// and a least-recently-released free list.
// ---------------------------------------------------------------------------
// Channel   Dir  Request contents
// i_req     in   func, device_id, block_number, buffer_index, mark_dirty
// o_rsp     out  slot, hit, need_read, need_write, error_code, last
//
// A sync emits one response per written-back buffer, up to MAX_OUT, since a
// priority pick finds the next dirty entry combinationally. Free-list
// updates go through single-port memories, one pointer access per cycle.
// After reset a clearing pass over all NUM_BUFFERS entries builds the free
// list; no request is taken meanwhile. A stalled output holds the sequencer.
// ---------------------------------------------------------------------------
module block_buffer_cache_manager import bbc_pkg::*; #(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int REF_WIDTH   = REF_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bbc_req_if.sink   i_req,
    bbc_rsp_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    bbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // Storage and result path.
    bbc_dpath #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .REF_WIDTH   (REF_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: src/bbc_ctrl.sv
// ---------------------------------------------------------------------------
// Buffer cache manager controller
// One-hot sequencer that steps the datapath through each request.
// ---------------------------------------------------------------------------
module bbc_ctrl import bbc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_sts i_sts,
    output logic o_req_ready,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_DECODE = 10'b0000000100,
        S_GETSEL = 10'b0000001000,
        S_RD     = 10'b0000010000,
        S_RM     = 10'b0000100000,
        S_REL    = 10'b0001000000,
        S_PUSH2  = 10'b0010000000,
        S_SYNC   = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_sts.func)
                    FUNC_GET:     n_state = S_GETSEL;
                    FUNC_RELEASE: n_state = S_REL;
                    FUNC_SYNC:    n_state = S_SYNC;
                    default:      n_state = S_EMIT;
                endcase
            end
            S_GETSEL: begin
                o_cmd.get_decide = 1'b1;
                if (i_sts.hit_any) begin
                    n_state = i_sts.hit_zero ? S_RD : S_EMIT;
                end else begin
                    n_state = i_sts.free_empty ? S_EMIT : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rm_rd = 1'b1;
                n_state     = S_RM;
            end
            S_RM: begin
                o_cmd.rm_upd = 1'b1;
                n_state      = S_EMIT;
            end
            S_REL: begin
                o_cmd.rel_decide = 1'b1;
                if (!i_sts.rel_bad && i_sts.rel_to_zero) n_state = S_PUSH2;
                else n_state = S_EMIT;
            end
            S_PUSH2: begin
                o_cmd.push2 = 1'b1;
                n_state     = S_EMIT;
            end
            S_SYNC: begin
                o_cmd.sync_step = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.pend_last ? S_IDLE : S_SYNC;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

FILE: src/bbc_dpath.sv
// ---------------------------------------------------------------------------
// Buffer cache manager datapath
// Tag store, counts, dirty marks, free-list memories and the result register.
// ---------------------------------------------------------------------------
module bbc_dpath import bbc_pkg::*; #(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int REF_WIDTH   = REF_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    bbc_req_if.sink   i_req,
    bbc_rsp_if.source o_rsp
);

    localparam int IW  = $clog2(NUM_BUFFERS);
    localparam int FCW = $clog2(NUM_BUFFERS + 1);
    localparam logic [IW-1:0]        LAST_IDX = IW'(NUM_BUFFERS - 1);
    localparam logic [REF_WIDTH-1:0] REF_MAX  = '1;

    // Per-entry state in flip-flops.
    logic [NUM_BUFFERS-1:0] r_valid;
    logic [DEV_W-1:0]       r_tdev [NUM_BUFFERS];
    logic [BLK_W-1:0]       r_tblk [NUM_BUFFERS];
    logic [REF_WIDTH-1:0]   r_cnt  [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_dirty;

    // Free-list memories.
    logic [IW-1:0] next_mem [NUM_BUFFERS];
    logic [IW-1:0] prev_mem [NUM_BUFFERS];
    logic [IW-1:0] r_rd_next, r_rd_prev;

    logic [IW-1:0]  r_head, r_tail, r_cur, r_init_cnt;
    logic [FCW-1:0] r_fc;

    // Latched request.
    logic [FUNC_W-1:0] r_func;
    logic [DEV_W-1:0]  r_dev;
    logic [BLK_W-1:0]  r_blk;
    logic [BIDX_W-1:0] r_bidx;
    logic              r_mark;
    logic [NUM_BUFFERS-1:0] r_match;
    logic [KCNT_W-1:0] r_k;

    // Pending and output results.
    logic [SLOT_W-1:0] r_p_slot, r_o_slot;
    logic              r_p_hit, r_p_rd, r_p_wr, r_p_last;
    logic [ERR_W-1:0]  r_p_err, r_o_err;
    logic              r_o_hit, r_o_rd, r_o_wr, r_o_last, r_o_valid;

    // Lowest set bit of a vector.
    function automatic logic [IW-1:0] f_first(input logic [NUM_BUFFERS-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int j = NUM_BUFFERS - 1; j >= 0; j--) begin
            if (v[j]) idx = IW'(j);
        end
        return idx;
    endfunction

    logic [IW-1:0]  hit_idx, rel_idx, sync_idx, push_at;
    logic           rel_ok;
    logic [NUM_BUFFERS-1:0] dirty_left;

    assign hit_idx    = f_first(r_match);
    assign rel_idx    = IW'(r_bidx);
    assign rel_ok     = (32'(r_bidx) < NUM_BUFFERS);
    assign sync_idx   = f_first(r_dirty);
    assign dirty_left = r_dirty & ~(NUM_BUFFERS'(1) << sync_idx);
    assign push_at    = (r_fc == '0) ? rel_idx : r_tail;

    // Status toward the controller.
    assign o_sts.init_last   = (r_init_cnt == LAST_IDX);
    assign o_sts.func        = r_func;
    assign o_sts.hit_any     = |r_match;
    assign o_sts.hit_zero    = (r_cnt[hit_idx] == '0);
    assign o_sts.free_empty  = (r_fc == '0);
    assign o_sts.rel_bad     = !rel_ok || (r_cnt[rel_idx] == '0);
    assign o_sts.rel_to_zero = (r_cnt[rel_idx] == REF_WIDTH'(1));
    assign o_sts.pend_last   = r_p_last;
    assign o_sts.out_free    = !r_o_valid || o_rsp.ready;

    // Write ports of the free-list memories.
    logic          nx_we, pv_we;
    logic [IW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

    always_comb begin
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        if (i_cmd.init_wr) begin
            nx_we = 1'b1; nx_wa = r_init_cnt;
            nx_wd = (r_init_cnt == LAST_IDX) ? '0 : r_init_cnt + 1'b1;
            pv_we = 1'b1; pv_wa = r_init_cnt;
            pv_wd = (r_init_cnt == '0) ? LAST_IDX : r_init_cnt - 1'b1;
        end else if (i_cmd.rm_upd) begin
            nx_we = (r_cur != r_head); nx_wa = r_rd_prev; nx_wd = r_rd_next;
            pv_we = (r_cur != r_tail); pv_wa = r_rd_next; pv_wd = r_rd_prev;
        end else if (i_cmd.rel_decide) begin
            nx_we = !o_sts.rel_bad && o_sts.rel_to_zero;
            nx_wa = push_at; nx_wd = rel_idx;
            pv_we = nx_we; pv_wa = rel_idx; pv_wd = push_at;
        end else if (i_cmd.push2) begin
            nx_we = 1'b1; nx_wa = rel_idx;
            nx_wd = (r_fc == '0) ? rel_idx : r_head;
        end
    end

    // Free-list memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        if (pv_we) prev_mem[pv_wa] <= pv_wd;
        if (i_cmd.rm_rd) begin
            r_rd_next <= next_mem[r_cur];
            r_rd_prev <= prev_mem[r_cur];
        end
    end

    // Control state: valid bits, counts, list pointers and the output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_dirty    <= '0;
            for (int j = 0; j < NUM_BUFFERS; j++) r_cnt[j] <= '0;
            r_head     <= '0;
            r_tail     <= LAST_IDX;
            r_fc       <= FCW'(NUM_BUFFERS);
            r_init_cnt <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.init_wr && !o_sts.init_last) r_init_cnt <= r_init_cnt + 1'b1;
            if (i_cmd.get_decide) begin
                if (|r_match) begin
                    if (r_cnt[hit_idx] != REF_MAX) r_cnt[hit_idx] <= r_cnt[hit_idx] + 1'b1;
                end else if (r_fc != '0) begin
                    r_valid[r_head] <= 1'b1;
                    r_cnt[r_head]   <= REF_WIDTH'(1);
                    r_dirty[r_head] <= 1'b0;
                end
            end
            if (i_cmd.rm_upd) begin
                if (r_cur == r_head) r_head <= r_rd_next;
                if (r_cur == r_tail) r_tail <= r_rd_prev;
                if (r_fc != '0) r_fc <= r_fc - 1'b1;
            end
            if (i_cmd.rel_decide && !o_sts.rel_bad) begin
                r_cnt[rel_idx] <= r_cnt[rel_idx] - 1'b1;
                r_dirty[rel_idx] <= o_sts.rel_to_zero ? 1'b0 : (r_dirty[rel_idx] | r_mark);
            end
            if (i_cmd.push2) begin
                if (r_fc == '0) r_head <= rel_idx;
                r_tail <= rel_idx;
                r_fc   <= r_fc + 1'b1;
            end
            if (i_cmd.sync_step && (r_dirty != '0)) r_dirty[sync_idx] <= 1'b0;
            if (i_cmd.out_load) r_o_valid <= 1'b1;
            else if (o_rsp.ready) r_o_valid <= 1'b0;
        end
    end

    // Payload registers: request latch, tag write, match vector, results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func <= i_req.func;
            r_dev  <= i_req.device_id;
            r_blk  <= i_req.block_number;
            r_bidx <= i_req.buffer_index;
            r_mark <= i_req.mark_dirty;
        end
        if (i_cmd.decode) begin
            for (int j = 0; j < NUM_BUFFERS; j++) begin
                r_match[j] <= r_valid[j] && (r_tdev[j] == r_dev) && (r_tblk[j] == r_blk);
            end
            r_k      <= '0;
            r_p_slot <= '0;
            r_p_hit  <= 1'b0;
            r_p_rd   <= 1'b0;
            r_p_wr   <= 1'b0;
            r_p_err  <= ERR_OK;
            r_p_last <= 1'b1;
        end
        if (i_cmd.get_decide) begin
            if (|r_match) begin
                r_cur    <= hit_idx;
                r_p_slot <= SLOT_W'(hit_idx);
                r_p_hit  <= 1'b1;
            end else if (r_fc != '0) begin
                r_cur          <= r_head;
                r_tdev[r_head] <= r_dev;
                r_tblk[r_head] <= r_blk;
                r_p_slot       <= SLOT_W'(r_head);
                r_p_rd         <= 1'b1;
            end else begin
                r_p_err <= ERR_NO_FREE;
            end
        end
        if (i_cmd.rel_decide) begin
            r_p_slot <= SLOT_W'(r_bidx);
            if (o_sts.rel_bad) r_p_err <= ERR_UNREF;
            else r_p_wr <= o_sts.rel_to_zero && (r_dirty[rel_idx] | r_mark);
        end
        if (i_cmd.sync_step) begin
            if (r_dirty != '0) begin
                r_p_slot <= SLOT_W'(sync_idx);
                r_p_wr   <= 1'b1;
                r_p_last <= (dirty_left == '0) || (r_k == KCNT_W'(MAX_OUT - 1));
                r_k      <= r_k + 1'b1;
            end else begin
                r_p_last <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_o_slot <= r_p_slot;
            r_o_hit  <= r_p_hit;
            r_o_rd   <= r_p_rd;
            r_o_wr   <= r_p_wr;
            r_o_err  <= r_p_err;
            r_o_last <= r_p_last;
        end
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.slot       = r_o_slot;
    assign o_rsp.hit        = r_o_hit;
    assign o_rsp.need_read  = r_o_rd;
    assign o_rsp.need_write = r_o_wr;
    assign o_rsp.error_code = r_o_err;
    assign o_rsp.last       = r_o_last;

endmodule
